>>> src/tcee_pkg.sv
// Shared constants, codes and types of the tracker channel effect engine.
package tcee_pkg;

  // Channel count and derived widths.
  localparam int NUM_CHANNELS = 4;
  localparam int CH_W         = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int MAX_OUT      = 4;
  localparam int OUT_CNT      = (NUM_CHANNELS < MAX_OUT) ? NUM_CHANNELS : MAX_OUT;

  // Fixed constants of the effect and gain arithmetic.
  localparam logic [15:0] PERIOD_FLOOR = 16'd56;
  localparam logic [7:0]  PAN_RIGHT    = 8'h80;
  localparam logic [7:0]  PAN_SURROUND = 8'hA4;
  localparam int          DIV_STEPS    = 24;

  // Effect command nibbles and extended sub-commands.
  localparam logic [3:0] EFX_PORTA_UP   = 4'h1;
  localparam logic [3:0] EFX_PORTA_DOWN = 4'h2;
  localparam logic [3:0] EFX_TONE       = 4'h3;
  localparam logic [3:0] EFX_TONE_VOL   = 4'h5;
  localparam logic [3:0] EFX_VIB_VOL    = 4'h6;
  localparam logic [3:0] EFX_VOL_SLIDE  = 4'hA;
  localparam logic [3:0] EFX_EXTENDED   = 4'hE;
  localparam logic [3:0] EXT_RETRIG     = 4'h9;
  localparam logic [3:0] EXT_CUT        = 4'hC;

  // Configuration register indexes.
  localparam logic [1:0] REG_MASTER_VOL = 2'd0;
  localparam logic [1:0] REG_STEP_NUM   = 2'd1;
  localparam logic [1:0] REG_MAX_VOL    = 2'd2;

  // Kind of an input item.
  typedef enum logic [1:0] {
    KIND_TICK = 2'd0,
    KIND_ROW  = 2'd1,
    KIND_LOAD = 2'd2,
    KIND_NONE = 2'd3
  } kind_t;

  // Controller states.
  typedef enum logic [3:0] {
    ST_IDLE, ST_DECODE, ST_LOAD, ST_EFF, ST_MOD_GO, ST_MOD_WAIT, ST_SEL,
    ST_GAIN1, ST_GAIN2, ST_DIV_GO, ST_DIV_WAIT, ST_EMIT, ST_ADV
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic tick_start;
    logic row_clear;
    logic load;
    logic eff;
    logic div_start;
    logic div_mod;
    logic mod_done;
    logic gain1;
    logic gain2;
    logic emit;
    logic next_ch;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    kind_t kind;
    logic  load_ok;
    logic  need_mod;
    logic  need_gain;
    logic  emit_en;
    logic  last_ch;
    logic  div_busy;
    logic  out_free;
  } dp_sts_t;

endpackage

>>> src/tcee_ctrl.sv
// Controller state machine that sequences loads, row starts and effect ticks.
module tcee_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  tcee_pkg::dp_sts_t   sts,
  output tcee_pkg::ctrl_cmd_t cmd
);

  tcee_pkg::state_t state_r, state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tcee_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      tcee_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.capture = 1'b1;
          state_nxt   = tcee_pkg::ST_DECODE;
        end
      end
      tcee_pkg::ST_DECODE: begin
        unique case (sts.kind)
          tcee_pkg::KIND_TICK: begin
            cmd.tick_start = 1'b1;
            state_nxt      = tcee_pkg::ST_EFF;
          end
          tcee_pkg::KIND_ROW: begin
            cmd.row_clear = 1'b1;
            state_nxt     = tcee_pkg::ST_IDLE;
          end
          tcee_pkg::KIND_LOAD: begin
            state_nxt = sts.load_ok ? tcee_pkg::ST_LOAD : tcee_pkg::ST_IDLE;
          end
          default: begin
            state_nxt = tcee_pkg::ST_IDLE;
          end
        endcase
      end
      tcee_pkg::ST_LOAD: begin
        cmd.load  = 1'b1;
        state_nxt = tcee_pkg::ST_GAIN1;
      end
      tcee_pkg::ST_EFF: begin
        cmd.eff   = 1'b1;
        state_nxt = sts.need_mod ? tcee_pkg::ST_MOD_GO : tcee_pkg::ST_SEL;
      end
      tcee_pkg::ST_MOD_GO: begin
        cmd.div_start = 1'b1;
        cmd.div_mod   = 1'b1;
        state_nxt     = tcee_pkg::ST_MOD_WAIT;
      end
      tcee_pkg::ST_MOD_WAIT: begin
        if (!sts.div_busy) begin
          cmd.mod_done = 1'b1;
          state_nxt    = tcee_pkg::ST_SEL;
        end
      end
      tcee_pkg::ST_SEL: begin
        if (sts.need_gain) begin
          state_nxt = tcee_pkg::ST_GAIN1;
        end else begin
          state_nxt = sts.emit_en ? tcee_pkg::ST_DIV_GO : tcee_pkg::ST_ADV;
        end
      end
      tcee_pkg::ST_GAIN1: begin
        cmd.gain1 = 1'b1;
        state_nxt = tcee_pkg::ST_GAIN2;
      end
      tcee_pkg::ST_GAIN2: begin
        cmd.gain2 = 1'b1;
        state_nxt = sts.emit_en ? tcee_pkg::ST_DIV_GO : tcee_pkg::ST_ADV;
      end
      tcee_pkg::ST_DIV_GO: begin
        cmd.div_start = 1'b1;
        state_nxt     = tcee_pkg::ST_DIV_WAIT;
      end
      tcee_pkg::ST_DIV_WAIT: begin
        if (!sts.div_busy) begin
          state_nxt = tcee_pkg::ST_EMIT;
        end
      end
      tcee_pkg::ST_EMIT: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = tcee_pkg::ST_ADV;
        end
      end
      tcee_pkg::ST_ADV: begin
        if (sts.kind == tcee_pkg::KIND_LOAD || sts.last_ch) begin
          state_nxt = tcee_pkg::ST_IDLE;
        end else begin
          cmd.next_ch = 1'b1;
          state_nxt   = tcee_pkg::ST_EFF;
        end
      end
      default: begin
        state_nxt = tcee_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

>>> src/tcee_dpath.sv
// Datapath: channel state, effect logic, gain pipeline, shared divider, output register.
module tcee_dpath (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [63:0]         in_tdata,
  input  logic [7:0]          in_tuser,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_addr,
  input  logic [23:0]         cfg_wdata,
  input  tcee_pkg::ctrl_cmd_t cmd,
  output tcee_pkg::dp_sts_t   sts,
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [47:0]         out_tdata,
  output logic                out_tlast
);

  localparam int N = tcee_pkg::NUM_CHANNELS;

  // Configuration registers.
  logic [7:0]  mvol_r, mvol_nxt;
  logic [23:0] snum_r, snum_nxt;
  logic [6:0]  maxv_r, maxv_nxt;

  // Captured input item.
  logic [63:0]     item_r, item_nxt;
  tcee_pkg::kind_t kind_r, kind_nxt;

  // Channel state.
  logic [15:0] period_r [N];
  logic [15:0] period_nxt [N];
  logic [6:0]  vol_r [N];
  logic [6:0]  vol_nxt [N];
  logic [7:0]  pan_r [N];
  logic [7:0]  pan_nxt [N];
  logic [11:0] effect_r [N];
  logic [11:0] effect_nxt [N];
  logic [11:0] target_r [N];
  logic [11:0] target_nxt [N];
  logic [7:0]  rate_r [N];
  logic [7:0]  rate_nxt [N];
  logic        active_r [N];
  logic        active_nxt [N];
  logic [9:0]  gl_r [N];
  logic [9:0]  gl_nxt [N];
  logic [9:0]  gr_r [N];
  logic [9:0]  gr_nxt [N];
  logic [7:0]  frame_r, frame_nxt;

  // Sequencing and per-channel scratch registers.
  logic [tcee_pkg::CH_W-1:0] ch_r, ch_nxt;
  logic       retrig_r, retrig_nxt;
  logic       need_gain_r, need_gain_nxt;
  logic [8:0] al_r, al_nxt;
  logic [8:0] ar_r, ar_nxt;

  // Divider registers.
  logic [23:0] quo_r, quo_nxt;
  logic [15:0] rem_r, rem_nxt;
  logic [15:0] den_r, den_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        dzero_r, dzero_nxt;

  // Output register.
  logic        ovalid_r, ovalid_nxt;
  logic [47:0] odata_r, odata_nxt;
  logic        olast_r, olast_nxt;

  // Input item fields.
  logic [1:0]  f_sel;
  logic [11:0] f_period;
  logic [6:0]  f_vol;
  logic [7:0]  f_pan;
  logic [11:0] f_eff;
  logic [11:0] f_tgt;
  logic [7:0]  f_rate;
  logic        f_restart;

  assign f_sel     = item_r[1:0];
  assign f_period  = item_r[13:2];
  assign f_vol     = item_r[20:14];
  assign f_pan     = item_r[28:21];
  assign f_eff     = item_r[40:29];
  assign f_tgt     = item_r[52:41];
  assign f_rate    = item_r[60:53];
  assign f_restart = item_r[61];

  // Current channel view.
  logic [15:0] c_p;
  logic [11:0] c_e;
  logic [3:0]  c_code, c_hi, c_lo;
  logic [7:0]  c_prm;
  logic [6:0]  c_vol;
  logic        c_act;
  logic [15:0] c_t;
  logic [7:0]  c_s;
  logic [16:0] up_lim, down_sum, tp_lo, tp_hi;
  logic [15:0] up_p, down_p, tone_p, eff_p;
  logic        slide_on, cut_hit, slide_fx;
  logic signed [8:0] slide_v;
  logic [6:0]  slide_vol, load_vol;
  logic [6:0]  a_vol;
  logic [15:0] gl_prod, gr_prod, gs_prod;
  logic [10:0] gl_sh, gr_sh, gs_sh;
  logic [8:0]  gl_sat, gr_sat, gs_sat;
  logic [7:0]  pan_left;
  logic [16:0] div_try;
  logic        div_ge;
  logic [23:0] step_q;

  assign c_p    = period_r[ch_r];
  assign c_e    = effect_r[ch_r];
  assign c_code = c_e[11:8];
  assign c_hi   = c_e[7:4];
  assign c_lo   = c_e[3:0];
  assign c_prm  = c_e[7:0];
  assign c_vol  = vol_r[ch_r];
  assign c_act  = active_r[ch_r];
  assign c_t    = {4'b0, target_r[ch_r]};
  assign c_s    = rate_r[ch_r];

  // Portamento up with floor, portamento down with saturation.
  assign up_lim   = {9'b0, c_prm} + {1'b0, tcee_pkg::PERIOD_FLOOR};
  assign up_p     = ({1'b0, c_p} <= up_lim) ? tcee_pkg::PERIOD_FLOOR : c_p - {8'b0, c_prm};
  assign down_sum = {1'b0, c_p} + {9'b0, c_prm};
  assign down_p   = down_sum[16] ? 16'hFFFF : down_sum[15:0];

  // Tone portamento toward the target, stopping on it.
  assign tp_lo = {1'b0, c_t} + {9'b0, c_s};
  assign tp_hi = {1'b0, c_p} + {9'b0, c_s};
  always_comb begin
    tone_p = c_p;
    if (c_p > c_t) begin
      tone_p = ({1'b0, c_p} < tp_lo) ? c_t : c_p - {8'b0, c_s};
    end else if (c_p < c_t) begin
      tone_p = (tp_hi > {1'b0, c_t}) ? c_t : tp_hi[15:0];
    end
  end

  // Period after the running effect.
  always_comb begin
    unique case (c_code)
      tcee_pkg::EFX_PORTA_UP:   eff_p = up_p;
      tcee_pkg::EFX_PORTA_DOWN: eff_p = down_p;
      tcee_pkg::EFX_TONE:       eff_p = tone_p;
      tcee_pkg::EFX_TONE_VOL:   eff_p = tone_p;
      default:                  eff_p = c_p;
    endcase
  end

  // Volume slide: up by the high nibble, else down by the low nibble, clamped.
  assign slide_on = (c_hi != 4'd0) || (c_lo != 4'd0);
  assign slide_v  = (c_hi != 4'd0) ? $signed({2'b0, c_vol}) + $signed({5'b0, c_hi})
                                   : $signed({2'b0, c_vol}) - $signed({5'b0, c_lo});
  always_comb begin
    if (slide_v < 0) begin
      slide_vol = 7'd0;
    end else if (slide_v > $signed({2'b0, maxv_r})) begin
      slide_vol = maxv_r;
    end else begin
      slide_vol = slide_v[6:0];
    end
  end
  assign load_vol = (f_vol > maxv_r) ? maxv_r : f_vol;

  assign slide_fx = (c_code == tcee_pkg::EFX_TONE_VOL) || (c_code == tcee_pkg::EFX_VIB_VOL)
                 || (c_code == tcee_pkg::EFX_VOL_SLIDE);
  assign cut_hit  = (c_code == tcee_pkg::EFX_EXTENDED) && (c_hi == tcee_pkg::EXT_CUT)
                 && (frame_r == {4'b0, c_lo});

  // Gain products from the registered pan terms.
  assign pan_left = tcee_pkg::PAN_RIGHT - pan_r[ch_r];
  assign a_vol    = vol_r[ch_r];
  assign gl_prod  = 16'(al_r) * 16'(a_vol);
  assign gr_prod  = 16'(ar_r) * 16'(a_vol);
  assign gs_prod  = 16'(mvol_r[7:1]) * 16'(a_vol);
  assign gl_sh    = gl_prod[15:5];
  assign gr_sh    = gr_prod[15:5];
  assign gs_sh    = gs_prod[15:5];
  assign gl_sat   = (gl_sh > 11'd511) ? 9'd511 : gl_sh[8:0];
  assign gr_sat   = (gr_sh > 11'd511) ? 9'd511 : gr_sh[8:0];
  assign gs_sat   = (gs_sh > 11'd511) ? 9'd511 : gs_sh[8:0];

  // One restoring division step.
  assign div_try = {rem_r, quo_r[23]};
  assign div_ge  = div_try >= {1'b0, den_r};
  assign step_q  = dzero_r ? 24'd0 : quo_r;

  // Next values of all registers.
  always_comb begin
    mvol_nxt    = mvol_r;
    snum_nxt    = snum_r;
    maxv_nxt    = maxv_r;
    item_nxt    = item_r;
    kind_nxt    = kind_r;
    frame_nxt   = frame_r;
    ch_nxt      = ch_r;
    retrig_nxt  = retrig_r;
    need_gain_nxt = need_gain_r;
    al_nxt      = al_r;
    ar_nxt      = ar_r;
    quo_nxt     = quo_r;
    rem_nxt     = rem_r;
    den_nxt     = den_r;
    cnt_nxt     = cnt_r;
    busy_nxt    = busy_r;
    dzero_nxt   = dzero_r;
    ovalid_nxt  = ovalid_r;
    odata_nxt   = odata_r;
    olast_nxt   = olast_r;
    for (int i = 0; i < N; i++) begin
      period_nxt[i] = period_r[i];
      vol_nxt[i]    = vol_r[i];
      pan_nxt[i]    = pan_r[i];
      effect_nxt[i] = effect_r[i];
      target_nxt[i] = target_r[i];
      rate_nxt[i]   = rate_r[i];
      active_nxt[i] = active_r[i];
      gl_nxt[i]     = gl_r[i];
      gr_nxt[i]     = gr_r[i];
    end

    // Configuration writes.
    if (cfg_we) begin
      unique case (cfg_addr)
        tcee_pkg::REG_MASTER_VOL: mvol_nxt = cfg_wdata[7:0];
        tcee_pkg::REG_STEP_NUM:   snum_nxt = cfg_wdata;
        tcee_pkg::REG_MAX_VOL:    maxv_nxt = cfg_wdata[6:0];
        default: ;
      endcase
    end

    // Item capture.
    if (cmd.capture) begin
      item_nxt = in_tdata;
      kind_nxt = tcee_pkg::kind_t'(in_tuser[1:0]);
      ch_nxt   = tcee_pkg::CH_W'(in_tdata[1:0]);
    end

    // Tick start: advance the frame counter and begin at channel zero.
    if (cmd.tick_start) begin
      frame_nxt = frame_r + 8'd1;
      ch_nxt    = '0;
    end

    // Row start: clear the frame counter and keep only the parameter bytes.
    if (cmd.row_clear) begin
      frame_nxt = 8'd0;
      for (int i = 0; i < N; i++) begin
        effect_nxt[i] = {4'b0, effect_r[i][7:0]};
      end
    end

    // Channel load.
    if (cmd.load) begin
      pan_nxt[ch_r]    = f_pan;
      effect_nxt[ch_r] = f_eff;
      target_nxt[ch_r] = f_tgt;
      rate_nxt[ch_r]   = f_rate;
      if (f_period != 12'd0) begin
        period_nxt[ch_r] = {4'b0, f_period};
      end
      vol_nxt[ch_r] = load_vol;
      if (f_restart) begin
        active_nxt[ch_r] = 1'b1;
      end
      retrig_nxt = f_restart;
    end

    // Effect of the current channel.
    if (cmd.eff) begin
      retrig_nxt    = 1'b0;
      need_gain_nxt = c_act && ((slide_fx && slide_on) || cut_hit);
      if (c_act) begin
        period_nxt[ch_r] = eff_p;
        if (slide_fx && slide_on) begin
          vol_nxt[ch_r] = slide_vol;
        end
        if (cut_hit) begin
          vol_nxt[ch_r]    = 7'd0;
          active_nxt[ch_r] = 1'b0;
        end
      end
    end

    if (cmd.mod_done) begin
      retrig_nxt = (rem_r == 16'd0);
    end

    // Gain pipeline, first stage: pan times master volume.
    if (cmd.gain1) begin
      al_nxt = 9'((16'(pan_left) * 16'(mvol_r)) >> 7);
      ar_nxt = 9'((16'(pan_r[ch_r]) * 16'(mvol_r)) >> 7);
    end

    // Gain pipeline, second stage: times volume, saturate, store.
    if (cmd.gain2) begin
      if (pan_r[ch_r] <= tcee_pkg::PAN_RIGHT) begin
        gl_nxt[ch_r] = {1'b0, gl_sat};
        gr_nxt[ch_r] = {1'b0, gr_sat};
      end else if (pan_r[ch_r] == tcee_pkg::PAN_SURROUND) begin
        gl_nxt[ch_r] = {1'b0, gs_sat};
        gr_nxt[ch_r] = 10'd0 - {1'b0, gs_sat};
      end
    end

    // Shared divider: step numerator over period, or frame count over x.
    if (cmd.div_start) begin
      rem_nxt  = 16'd0;
      cnt_nxt  = 5'(tcee_pkg::DIV_STEPS);
      busy_nxt = 1'b1;
      if (cmd.div_mod) begin
        quo_nxt   = {16'b0, frame_r};
        den_nxt   = {12'b0, c_lo};
        dzero_nxt = 1'b0;
      end else begin
        quo_nxt   = snum_r;
        den_nxt   = c_p;
        dzero_nxt = (c_p == 16'd0);
      end
    end else if (busy_r) begin
      rem_nxt  = div_ge ? 16'(div_try - {1'b0, den_r}) : div_try[15:0];
      quo_nxt  = {quo_r[22:0], div_ge};
      cnt_nxt  = cnt_r - 5'd1;
      busy_nxt = (cnt_r != 5'd1);
    end

    // Output register.
    if (cmd.emit) begin
      ovalid_nxt = 1'b1;
      odata_nxt  = {retrig_r, active_r[ch_r], gr_r[ch_r], gl_r[ch_r],
                    step_q[15:0], step_q[23:16], 2'(ch_r)};
      olast_nxt  = (kind_r == tcee_pkg::KIND_LOAD)
                || (32'(ch_r) == tcee_pkg::OUT_CNT - 1);
    end else if (out_tready) begin
      ovalid_nxt = 1'b0;
    end

    if (cmd.next_ch) begin
      ch_nxt = ch_r + tcee_pkg::CH_W'(1);
    end
  end

  // Registers with reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mvol_r   <= 8'd32;
      snum_r   <= 24'd9774717;
      maxv_r   <= 7'd64;
      frame_r  <= 8'd0;
      busy_r   <= 1'b0;
      ovalid_r <= 1'b0;
      for (int i = 0; i < N; i++) begin
        period_r[i] <= 16'd0;
        vol_r[i]    <= 7'd0;
        pan_r[i]    <= 8'd64;
        effect_r[i] <= 12'd0;
        target_r[i] <= 12'd0;
        rate_r[i]   <= 8'd0;
        active_r[i] <= 1'b0;
        gl_r[i]     <= 10'd0;
        gr_r[i]     <= 10'd0;
      end
    end else begin
      mvol_r   <= mvol_nxt;
      snum_r   <= snum_nxt;
      maxv_r   <= maxv_nxt;
      frame_r  <= frame_nxt;
      busy_r   <= busy_nxt;
      ovalid_r <= ovalid_nxt;
      for (int i = 0; i < N; i++) begin
        period_r[i] <= period_nxt[i];
        vol_r[i]    <= vol_nxt[i];
        pan_r[i]    <= pan_nxt[i];
        effect_r[i] <= effect_nxt[i];
        target_r[i] <= target_nxt[i];
        rate_r[i]   <= rate_nxt[i];
        active_r[i] <= active_nxt[i];
        gl_r[i]     <= gl_nxt[i];
        gr_r[i]     <= gr_nxt[i];
      end
    end
  end

  // Payload and scratch registers.
  always_ff @(posedge clk) begin
    item_r      <= item_nxt;
    kind_r      <= kind_nxt;
    ch_r        <= ch_nxt;
    retrig_r    <= retrig_nxt;
    need_gain_r <= need_gain_nxt;
    al_r        <= al_nxt;
    ar_r        <= ar_nxt;
    quo_r       <= quo_nxt;
    rem_r       <= rem_nxt;
    den_r       <= den_nxt;
    cnt_r       <= cnt_nxt;
    dzero_r     <= dzero_nxt;
    odata_r     <= odata_nxt;
    olast_r     <= olast_nxt;
  end

  // Status to the controller.
  assign sts.kind      = kind_r;
  assign sts.load_ok   = ({30'b0, f_sel} < 32'(N));
  assign sts.need_mod  = c_act && (c_code == tcee_pkg::EFX_EXTENDED)
                      && (c_hi == tcee_pkg::EXT_RETRIG) && (c_lo != 4'd0);
  assign sts.need_gain = need_gain_r;
  assign sts.emit_en   = (kind_r == tcee_pkg::KIND_LOAD) || (32'(ch_r) < tcee_pkg::OUT_CNT);
  assign sts.last_ch   = (32'(ch_r) == N - 1);
  assign sts.div_busy  = busy_r;
  assign sts.out_free  = !ovalid_r || out_tready;

  assign out_tvalid = ovalid_r;
  assign out_tdata  = odata_r;
  assign out_tlast  = olast_r;

endmodule

>>> src/tracker_channel_effect_engine_top.sv
// Top level of the tracker channel effect engine: controller plus datapath.
// A load item has its result registered after the gain stages and the 24-step divider;
// the next item is taken after that result is registered.
// A tick item walks every channel; each emitted channel runs the divider, after the gain
// stages when its gains are recomputed, and a retrigger check first uses the same divider
// for the remainder. A result that waits on out_tready holds the channel walk.
// One item is in work at a time; the next is taken once the last result is registered.
// Synchronous active-low reset restores configuration and channel state to defaults.
module tracker_channel_effect_engine_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // chan_sel, note_period, note_volume, pan_pos, effect_word, porta_target,
  // porta_rate, restart (from bit 0 up), zero filled to 64 bits
  input  logic [63:0] in_tdata,
  // cmd in bits 1:0, zero filled to 8 bits
  input  logic [7:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // out_chan, step_whole, step_part, gain_left, gain_right, is_active,
  // retrigger (from bit 0 up)
  output logic [47:0] out_tdata,
  output logic        out_tlast,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [23:0] cfg_wdata
);

  tcee_pkg::ctrl_cmd_t cmd;
  tcee_pkg::dp_sts_t   sts;

  tcee_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  tcee_dpath u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .cmd        (cmd),
    .sts        (sts),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  // One item at a time: no new item right after one is taken.
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input taken twice in a row");

  // The divider is busy right after it is started.
  a_div_start: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |=> sts.div_busy)
    else $error("divider did not start");

  // A result is only loaded when the output register is free.
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> sts.out_free)
    else $error("result overwritten");

  // No divider start while it is still running.
  a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |-> !sts.div_busy)
    else $error("divider restarted while busy");

endmodule
